@@ design/rss_pkg.sv @@
// ----------------------------------------------------------------------------
// rss_pkg
// Types and constants shared by the record selection sort unit.
// ----------------------------------------------------------------------------
package rss_pkg;

	localparam int unsigned MAX_RECORDS_DEF = 32;
	localparam int unsigned MAX_OUT         = 32;
	localparam int unsigned CNT_W           = 6;
	localparam logic [CNT_W-1:0] REPORT_RESET = 6'd5;

	typedef struct packed {
		logic [7:0]  item_code;
		logic [15:0] quantity;
		logic [23:0] price_cents;
		logic [7:0]  record_tag;
		logic        last_item;
	} rss_in_t;

	typedef struct packed {
		logic [7:0]  out_code;
		logic [15:0] out_quantity;
		logic [23:0] out_price_cents;
		logic [7:0]  out_tag;
		logic        out_last;
	} rss_out_t;

	typedef struct packed {
		logic [7:0]  code;
		logic [15:0] quantity;
		logic [23:0] price_cents;
		logic [7:0]  tag;
	} rss_rec_t;

	typedef struct packed {
		logic ld_en;
		logic sort_init;
		logic scan_rd;
		logic swap_a;
		logic swap_b;
		logic emit_init;
		logic emit_rd;
		logic out_load;
	} rss_cmd_t;

	typedef struct packed {
		logic need_sort;
		logic scan_last;
		logic sort_more;
		logic k_zero;
		logic emit_last;
		logic out_free;
	} rss_sts_t;

endpackage

@@ design/rss_ctrl.sv @@
// ----------------------------------------------------------------------------
// rss_ctrl
// Sequencer for load, selection sort passes and report emission.
// ----------------------------------------------------------------------------
module rss_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rec_valid,
	input  logic             rec_last,
	input  rss_pkg::rss_sts_t sts,
	output rss_pkg::rss_cmd_t cmd,
	output logic             rec_stall
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SORT_INIT,
		ST_SCAN,
		ST_SCAN_END,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign rec_stall = (state_q != ST_LOAD);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (rec_valid) begin
					cmd.ld_en = 1'b1;
					if (rec_last)
						state_d = ST_SORT_INIT;
				end
			end
			ST_SORT_INIT: begin
				cmd.sort_init = 1'b1;
				state_d = sts.need_sort ? ST_SCAN : ST_SWAP_B;
				if (!sts.need_sort) begin
					cmd.sort_init = 1'b1;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last)
					state_d = ST_SCAN_END;
			end
			ST_SCAN_END: begin
				state_d = ST_SWAP_A;
			end
			ST_SWAP_A: begin
				cmd.swap_a = 1'b1;
				state_d = ST_SWAP_B;
			end
			ST_SWAP_B: begin
				if (sts.need_sort && sts.sort_more) begin
					cmd.swap_b = 1'b1;
					state_d = ST_SCAN;
				end else begin
					cmd.swap_b    = sts.need_sort;
					cmd.emit_init = 1'b1;
					state_d = sts.k_zero ? ST_LOAD : ST_EMIT_RD;
				end
			end
			ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_d = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = sts.emit_last ? ST_LOAD : ST_EMIT_RD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ design/rss_dpath.sv @@
// ----------------------------------------------------------------------------
// rss_dpath
// Record store, scan compare, swap and report output register.
// ----------------------------------------------------------------------------
module rss_dpath #(
	parameter int unsigned MAX_RECORDS = rss_pkg::MAX_RECORDS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rss_pkg::rss_in_t            rec,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [rss_pkg::CNT_W-1:0]   cfg_data,
	input  rss_pkg::rss_cmd_t           cmd,
	output rss_pkg::rss_sts_t           sts,
	output logic                        rpt_valid,
	input  logic                        rpt_stall,
	output rss_pkg::rss_out_t           rpt
);

	localparam int unsigned AW = $clog2(MAX_RECORDS);
	localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
	localparam int unsigned MW = (CW > rss_pkg::CNT_W) ? CW : rss_pkg::CNT_W;

	rss_pkg::rss_rec_t mem [MAX_RECORDS];

	rss_pkg::rss_rec_t rdata_q;
	rss_pkg::rss_rec_t best_q;
	rss_pkg::rss_rec_t head_rec_q;
	rss_pkg::rss_out_t rpt_q;

	logic [rss_pkg::CNT_W-1:0] report_q;
	logic [CW-1:0]             cnt_q;
	logic [AW-1:0]             head_q;
	logic [AW-1:0]             j_q;
	logic [AW-1:0]             best_idx_q;
	logic [AW-1:0]             i_q;
	logic [AW-1:0]             j_s1;
	logic                      v_s1;
	logic [MW-1:0]             k_q;
	logic                      rpt_valid_q;

	logic [MW-1:0]             k_a;
	logic [MW-1:0]             k_d;
	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	rss_pkg::rss_rec_t         wr_data;
	logic [AW-1:0]             rd_addr;
	rss_pkg::rss_rec_t         in_rec;

	assign in_rec = '{code: rec.item_code, quantity: rec.quantity,
		price_cents: rec.price_cents, tag: rec.record_tag};

	always_comb begin
		k_a = (MW'(report_q) < MW'(cnt_q)) ? MW'(report_q) : MW'(cnt_q);
		k_d = (k_a < MW'(rss_pkg::MAX_OUT)) ? k_a : MW'(rss_pkg::MAX_OUT);
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[AW-1:0];
		wr_data = in_rec;
		if (cmd.ld_en && (cnt_q < CW'(MAX_RECORDS))) begin
			wr_en = 1'b1;
		end else if (cmd.swap_a) begin
			wr_en   = 1'b1;
			wr_addr = best_idx_q;
			wr_data = head_rec_q;
		end else if (cmd.swap_b) begin
			wr_en   = 1'b1;
			wr_addr = head_q;
			wr_data = best_q;
		end
	end

	assign rd_addr = cmd.emit_rd ? i_q : j_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.scan_rd || cmd.emit_rd)
			rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			if (j_s1 == head_q) begin
				best_q     <= rdata_q;
				head_rec_q <= rdata_q;
				best_idx_q <= j_s1;
			end else if (rdata_q.quantity < best_q.quantity) begin
				best_q     <= rdata_q;
				best_idx_q <= j_s1;
			end
		end
		if (cmd.scan_rd)
			j_s1 <= j_q;
		if (cmd.out_load) begin
			rpt_q.out_code        <= rdata_q.code;
			rpt_q.out_quantity    <= rdata_q.quantity;
			rpt_q.out_price_cents <= rdata_q.price_cents;
			rpt_q.out_tag         <= rdata_q.tag;
			rpt_q.out_last        <= sts.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_q    <= rss_pkg::REPORT_RESET;
			cnt_q       <= '0;
			head_q      <= '0;
			j_q         <= '0;
			i_q         <= '0;
			k_q         <= '0;
			v_s1        <= 1'b0;
			rpt_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				report_q <= cfg_data;
			if (cmd.ld_en && (cnt_q < CW'(MAX_RECORDS)))
				cnt_q <= cnt_q + CW'(1);
			else if (cmd.emit_init)
				cnt_q <= '0;
			if (cmd.sort_init) begin
				head_q <= '0;
				j_q    <= '0;
				k_q    <= k_d;
			end else if (cmd.swap_b) begin
				head_q <= head_q + AW'(1);
				j_q    <= head_q + AW'(1);
			end else if (cmd.scan_rd) begin
				j_q <= j_q + AW'(1);
			end
			v_s1 <= cmd.scan_rd;
			if (cmd.emit_init)
				i_q <= '0;
			else if (cmd.out_load)
				i_q <= i_q + AW'(1);
			if (cmd.out_load)
				rpt_valid_q <= 1'b1;
			else if (!rpt_stall)
				rpt_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.need_sort = (cnt_q >= CW'(2));
		sts.scan_last = ((CW'(j_q) + CW'(1)) == cnt_q);
		sts.sort_more = (((CW+1)'(head_q) + (CW+1)'(2)) < (CW+1)'(cnt_q));
		sts.k_zero    = (k_q == '0);
		sts.emit_last = ((MW'(i_q) + MW'(1)) == k_q);
		sts.out_free  = !rpt_valid_q || !rpt_stall;
	end

	assign rpt_valid = rpt_valid_q;
	assign rpt       = rpt_q;

endmodule

@@ design/record_selection_sort_unit.sv @@
// ----------------------------------------------------------------------------
// record_selection_sort_unit
// Low-stock report: stores a set of records, selection-sorts them by
// quantity and emits the first report_count, capped at the records held and MAX_OUT.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | beat
//  rec      | in        | rec_valid/rec_stall  | one record, last_item closes set
//  rpt      | out       | rpt_valid/rpt_stall  | one reported record, out_last marks end
//  cfg      | in        | cfg_valid/cfg_ready  | report_count, 6 bits
//
//  Loading accepts one record per cycle while rec_stall is low. With n >= 2
//  records held, sort pass h scans records h to n-1 through the single store
//  read port and swaps the lowest quantity into slot h; each result is then
//  read from the store and loaded into the output register before the next.
//  Reset clears control state and sets report_count to 5; the store is not
//  cleared. rec_stall is high from the closing beat until the last result
//  has entered the output register; rpt_stall holds that register.
// ----------------------------------------------------------------------------
module record_selection_sort_unit #(
	parameter int unsigned MAX_RECORDS = rss_pkg::MAX_RECORDS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rec_valid,
	output logic                      rec_stall,
	input  rss_pkg::rss_in_t          rec,
	output logic                      rpt_valid,
	input  logic                      rpt_stall,
	output rss_pkg::rss_out_t         rpt,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [rss_pkg::CNT_W-1:0] cfg_data
);

	rss_pkg::rss_cmd_t cmd;
	rss_pkg::rss_sts_t sts;

	assign cfg_ready = 1'b1;

	rss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec_last  (rec.last_item),
		.sts       (sts),
		.cmd       (cmd),
		.rec_stall (rec_stall)
	);

	rss_dpath #(
		.MAX_RECORDS (MAX_RECORDS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec       (rec),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.rpt_valid (rpt_valid),
		.rpt_stall (rpt_stall),
		.rpt       (rpt)
	);

endmodule
